FILE: hw/rtl/kempner_function_macros.svh
// Assertion macros used by the kempner_function checker.
`ifndef KEMPNER_FUNCTION_MACROS_SVH
`define KEMPNER_FUNCTION_MACROS_SVH

// Check cons in the cycle after ante, outside reset.
`define KF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kempner_function check failed");

// Check cons in the cycle after ante, reset included.
`define KF_ASSERT_NEXT_RAW(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("kempner_function check failed");

`endif

FILE: hw/rtl/kf_pkg.sv
// Shared widths, types and command/status structs for the Kempner function block.
`timescale 1ns / 1ps
package kf_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] t_value;

    typedef struct packed {
        logic load;
        logic step_lam;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic rest_done;
        logic gcd_equal;
        logic gcd_is_one;
        logic div_last;
    } t_status;

endpackage

FILE: hw/rtl/kf_dp.sv
// Datapath: remainder, lambda counter, subtractive gcd and bit-serial exact divider.
`timescale 1ns / 1ps
module kf_dp (
    input  logic            i_clk,
    input  kf_pkg::t_cmd    i_cmd,
    input  kf_pkg::t_value  i_value,
    output kf_pkg::t_status o_status,
    output kf_pkg::t_value  o_result
);
    import kf_pkg::*;

    t_value           r_rest;
    t_value           r_lam;
    t_value           r_ga;
    t_value           r_gb;
    t_value           r_quo;
    t_value           r_rem;
    logic [CNT_W-1:0] r_cnt;
    t_value           r_result;

    t_value           lam_inc;
    logic [VALUE_WIDTH:0] rem_sh;
    logic             ge;
    logic [VALUE_WIDTH:0] rem_diff;
    t_value           n_rem;
    t_value           n_quo;

    assign lam_inc  = r_lam + t_value'(1);
    assign rem_sh   = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign ge       = rem_sh >= {1'b0, r_ga};
    assign rem_diff = rem_sh - {1'b0, r_ga};
    assign n_rem    = ge ? rem_diff[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
    assign n_quo    = {r_quo[VALUE_WIDTH-2:0], ge};

    assign o_status.rest_done  = (r_rest == t_value'(1)) || (r_rest == '0);
    assign o_status.gcd_equal  = (r_ga == r_gb);
    assign o_status.gcd_is_one = (r_ga == t_value'(1));
    assign o_status.div_last   = (r_cnt == CNT_W'(VALUE_WIDTH - 1));
    assign o_result            = r_result;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rest <= i_value;
            r_lam  <= t_value'(1);
        end
        if (i_cmd.step_lam) begin
            r_lam <= lam_inc;
            r_ga  <= r_rest;
            r_gb  <= lam_inc;
        end
        if (i_cmd.gcd_step) begin
            if (r_ga > r_gb) begin
                r_ga <= r_ga - r_gb;
            end else begin
                r_gb <= r_gb - r_ga;
            end
        end
        if (i_cmd.div_start) begin
            r_quo <= r_rest;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_cnt <= r_cnt + CNT_W'(1);
            if (o_status.div_last) begin
                r_rest <= n_quo;
            end
        end
        if (i_cmd.load_out) begin
            r_result <= (r_rest == '0) ? '0 : r_lam;
        end
    end

endmodule

FILE: hw/rtl/kf_ctrl.sv
// Controller: sequences lambda steps, gcd, division and the output register handshake.
`timescale 1ns / 1ps
module kf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  kf_pkg::t_status i_status,
    output kf_pkg::t_cmd    o_cmd
);
    import kf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_GCD   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.rest_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.step_lam = 1'b1;
                    n_state        = S_GCD;
                end
            end
            S_GCD: begin
                if (i_status.gcd_equal) begin
                    if (i_status.gcd_is_one) begin
                        n_state = S_CHECK;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_CHECK;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: hw/rtl/kempner_function.sv
// The run time depends on the result: each lambda from 2 up to the result takes a subtractive
// gcd of remainder and lambda, and a division of the remainder by that gcd when it exceeds 1.
// The subtractive gcd dominates the run time.
// One transaction at a time; the next is taken as soon as the result is in the
// output register, while that result still waits to be taken.
// Reset clears the controller state and the output valid; payload registers are not reset.
`timescale 1ns / 1ps
module kempner_function (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kf_pkg::t_value i_value,
    output logic           o_valid,
    input  logic           i_ready,
    output kf_pkg::t_value o_least_lambda
);
    import kf_pkg::*;

    t_cmd    cmd;
    t_status status;

    kf_ctrl u_kf_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    kf_dp u_kf_dp (
        .i_clk    (i_clk),
        .i_cmd    (cmd),
        .i_value  (i_value),
        .o_status (status),
        .o_result (o_least_lambda)
    );

endmodule

FILE: hw/rtl/kf_checker.sv
// Port-level checker for kempner_function and its bind.
`timescale 1ns / 1ps
`include "kempner_function_macros.svh"
module kf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input kf_pkg::t_value i_least_lambda
);
    import kf_pkg::*;

    `KF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    `KF_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_least_lambda))
    `KF_ASSERT_NEXT_RAW(a_reset_empty, !i_rst_n, !i_out_valid && i_in_ready)
    `KF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind kempner_function kf_checker u_kf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_valid),
    .i_in_ready     (o_ready),
    .i_out_valid    (o_valid),
    .i_out_ready    (i_ready),
    .i_least_lambda (o_least_lambda)
);
